FILE: rtl/mecr_pkg.sv
// ----------------------------------------------------------------------------
// mecr_pkg: shared types and constants for the min-eigenvalue corner block
// Window geometry, field widths, register indexes, controller/datapath structs.
// ----------------------------------------------------------------------------
package mecr_pkg;

  localparam int RADIUS      = 7;
  localparam int WIN_DIAM    = 2 * RADIUS + 1;      // 15 columns in the window
  localparam int STORE_ROWS  = 2 * RADIUS + 3;      // 17 rows held in the line store
  localparam int EDGE        = 2 * RADIUS + 2;      // first row/col that can close a window
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;

  localparam int PIX_W       = 8;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int SLOT_W      = 5;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int WID_W       = 11;
  localparam int HGT_W       = 13;
  localparam int CFG_W       = 13;

  localparam int CS_U_W      = 20;                  // column sum of squares
  localparam int CS_S_W      = 21;                  // column sum of cross products
  localparam int WIN_U_W     = 24;
  localparam int WIN_S_W     = 25;
  localparam int SQ_W        = 48;
  localparam int DISC_W      = 52;
  localparam int ROOT_W      = 26;
  localparam int REM_W       = 29;
  localparam int RESP_W      = 25;
  localparam int K_W         = 5;
  localparam int IT_W        = 5;

  localparam int OUT_DATA_W  = 48;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_IMAGE_WIDTH  = 1'b0;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_MID,
    SIDE_RIGHT
  } side_t;

  typedef struct packed {
    logic  accept;    // input word taken this cycle
    logic  col_clr;   // start a column pass
    logic  rd_en;
    side_t rd_side;
    logic  rd_grad;   // this read row closes a gradient row
    logic  win_upd;
    logic  mul_sq;
    logic  mul_disc;
    logic  sq_step;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_col;
    logic emit;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/mecr_ram.sv
// ----------------------------------------------------------------------------
// mecr_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mecr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/mecr_ctrl.sv
// ----------------------------------------------------------------------------
// mecr_ctrl: sequencer for the corner response datapath
// Steps the column pass, window update, multiply, square root and output load as each pixel needs them.
// ----------------------------------------------------------------------------
module mecr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  mecr_pkg::dp_stat_t   stat,
  output mecr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_FLUSH,
    S_WIN,
    S_MUL,
    S_DISC,
    S_SQRT,
    S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mecr_pkg::K_W-1:0]   k_r, k_nxt;
  mecr_pkg::side_t            side_r, side_nxt;
  logic [mecr_pkg::IT_W-1:0]  it_r, it_nxt;

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    side_nxt    = side_r;
    it_nxt      = it_r;
    cmd         = '0;
    cmd.rd_side = side_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.need_col) begin
            cmd.col_clr = 1'b1;
            k_nxt       = '0;
            side_nxt    = mecr_pkg::SIDE_LEFT;
            state_nxt   = S_COL;
          end
        end
      end
      S_COL: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_grad = (k_r >= mecr_pkg::K_W'(2));
        case (side_r)
          mecr_pkg::SIDE_LEFT: side_nxt = mecr_pkg::SIDE_MID;
          mecr_pkg::SIDE_MID:  side_nxt = mecr_pkg::SIDE_RIGHT;
          default: begin
            side_nxt = mecr_pkg::SIDE_LEFT;
            if (k_r == mecr_pkg::K_W'(mecr_pkg::STORE_ROWS - 1)) begin
              state_nxt = S_FLUSH;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        endcase
      end
      S_FLUSH: state_nxt = S_WIN;
      S_WIN: begin
        cmd.win_upd = 1'b1;
        state_nxt   = stat.emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = S_DISC;
      end
      S_DISC: begin
        cmd.mul_disc = 1'b1;
        it_nxt       = '0;
        state_nxt    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (it_r == mecr_pkg::IT_W'(mecr_pkg::ROOT_W - 1)) begin
          state_nxt = S_OUT;
        end else begin
          it_nxt = it_r + 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      side_r  <= mecr_pkg::SIDE_LEFT;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      side_r  <= side_nxt;
      it_r    <= it_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

FILE: rtl/mecr_dp.sv
// ----------------------------------------------------------------------------
// mecr_dp: datapath of the corner response block
// Position counters, line store, column and window tensor sums, root unit.
// ----------------------------------------------------------------------------
module mecr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  mecr_pkg::reg_idx_t                    cfg_index,
  input  logic [mecr_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [mecr_pkg::PIX_W-1:0]            in_green,
  input  logic                                  in_frame_start,
  input  mecr_pkg::ctrl_cmd_t                   cmd,
  output mecr_pkg::dp_stat_t                    stat,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [mecr_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);

  localparam int COL_W  = mecr_pkg::COL_W;
  localparam int ROW_W  = mecr_pkg::ROW_W;
  localparam int SLOT_W = mecr_pkg::SLOT_W;
  localparam int NCOL   = mecr_pkg::WIN_DIAM;

  // ---------------- configuration ----------------
  logic [mecr_pkg::WID_W-1:0] w_r, w_eff;
  logic [mecr_pkg::HGT_W-1:0] h_r, h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= mecr_pkg::WID_W'(640);
      h_r <= mecr_pkg::HGT_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        mecr_pkg::REG_IMAGE_WIDTH:  w_r <= cfg_wdata[mecr_pkg::WID_W-1:0];
        mecr_pkg::REG_IMAGE_HEIGHT: h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (w_r == '0) w_eff = mecr_pkg::WID_W'(1);
    else if (w_r > mecr_pkg::WID_W'(mecr_pkg::MAX_WIDTH)) w_eff = mecr_pkg::WID_W'(mecr_pkg::MAX_WIDTH);
    else w_eff = w_r;
    if (h_r == '0) h_eff = mecr_pkg::HGT_W'(1);
    else if (h_r > mecr_pkg::HGT_W'(mecr_pkg::MAX_HEIGHT)) h_eff = mecr_pkg::HGT_W'(mecr_pkg::MAX_HEIGHT);
    else h_eff = h_r;
  end

  // ---------------- position counters ----------------
  logic [COL_W-1:0]  col_r, col_cur, col_nxt;
  logic [ROW_W-1:0]  row_r, row_cur, row_nxt;
  logic [SLOT_W-1:0] rslot_r, slot_cur, slot_cur_inc, rslot_nxt;
  logic              col_last, row_last, emit_now, last_now;

  assign col_cur      = in_frame_start ? '0 : col_r;
  assign row_cur      = in_frame_start ? '0 : row_r;
  assign slot_cur     = in_frame_start ? '0 : rslot_r;
  assign slot_cur_inc = (slot_cur == SLOT_W'(mecr_pkg::STORE_ROWS - 1)) ? '0 : slot_cur + 1'b1;
  assign col_last     = ({1'b0, col_cur} + mecr_pkg::WID_W'(1)) >= w_eff;
  assign row_last     = ({1'b0, row_cur} + mecr_pkg::HGT_W'(1)) >= h_eff;

  always_comb begin
    if (col_last) begin
      col_nxt   = '0;
      row_nxt   = row_last ? '0 : row_cur + 1'b1;
      rslot_nxt = row_last ? '0 : slot_cur_inc;
    end else begin
      col_nxt   = col_cur + 1'b1;
      row_nxt   = row_cur;
      rslot_nxt = slot_cur;
    end
  end

  assign emit_now = (col_cur >= COL_W'(mecr_pkg::EDGE)) && ({1'b0, col_cur} < w_eff) &&
                    (row_cur >= ROW_W'(mecr_pkg::EDGE)) && ({1'b0, row_cur} < h_eff);
  assign last_now = ({1'b0, col_cur} == w_eff - 1'b1) && ({1'b0, row_cur} == h_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      rslot_r <= '0;
    end else if (cmd.accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rslot_r <= rslot_nxt;
    end
  end

  logic [COL_W-1:0] pcol_r;
  logic [ROW_W-1:0] prow_r;
  logic             emit_r, plast_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pcol_r  <= col_cur;
      prow_r  <= row_cur;
      emit_r  <= emit_now;
      plast_r <= last_now;
    end
  end

  assign stat.need_col = (row_cur >= ROW_W'(mecr_pkg::EDGE)) && (col_cur != '0);
  assign stat.emit     = emit_r;

  // ---------------- line store ----------------
  logic [SLOT_W-1:0]               slot_r, slot_r_inc;
  logic [COL_W-1:0]                rd_col;
  logic [mecr_pkg::ADDR_W-1:0]     ram_addr;
  logic [mecr_pkg::PIX_W-1:0]      ram_q;

  assign slot_r_inc = (slot_r == SLOT_W'(mecr_pkg::STORE_ROWS - 1)) ? '0 : slot_r + 1'b1;

  always_comb begin
    case (cmd.rd_side)
      mecr_pkg::SIDE_LEFT: rd_col = pcol_r - COL_W'(2);
      mecr_pkg::SIDE_MID:  rd_col = pcol_r - COL_W'(1);
      default:             rd_col = pcol_r;
    endcase
  end

  assign ram_addr = cmd.accept ? {slot_cur, col_cur} : {slot_r, rd_col};

  // first read row of a pass is the oldest stored row
  always_ff @(posedge clk) begin
    if (cmd.col_clr) begin
      slot_r <= slot_cur_inc;
    end else if (cmd.rd_en && cmd.rd_side == mecr_pkg::SIDE_RIGHT) begin
      slot_r <= slot_r_inc;
    end
  end

  mecr_ram #(
    .WIDTH (mecr_pkg::PIX_W),
    .DEPTH (mecr_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.accept),
    .addr  (ram_addr),
    .wdata (in_green),
    .rdata (ram_q)
  );

  // ---------------- column pass ----------------
  logic            rv_r, rgrad_r;
  mecr_pkg::side_t rside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.rd_en;
    end
    rside_r <= cmd.rd_side;
    rgrad_r <= cmd.rd_grad;
  end

  logic [mecr_pkg::PIX_W-1:0] l_cur_r, m_cur_r, pl_r, pr_r, m1_r, m2_r;
  logic signed [8:0]          ix, iy;
  logic signed [17:0]         pxx, pyy, pxy;
  logic [mecr_pkg::CS_U_W-1:0]        cs_xx_r, cs_yy_r;
  logic signed [mecr_pkg::CS_S_W-1:0] cs_xy_r;

  assign ix  = {1'b0, pr_r} - {1'b0, pl_r};
  assign iy  = {1'b0, m_cur_r} - {1'b0, m2_r};
  assign pxx = ix * ix;
  assign pyy = iy * iy;
  assign pxy = ix * iy;

  always_ff @(posedge clk) begin
    if (cmd.col_clr) begin
      cs_xx_r <= '0;
      cs_yy_r <= '0;
      cs_xy_r <= '0;
    end else if (rv_r) begin
      case (rside_r)
        mecr_pkg::SIDE_LEFT: l_cur_r <= ram_q;
        mecr_pkg::SIDE_MID:  m_cur_r <= ram_q;
        default: begin
          if (rgrad_r) begin
            cs_xx_r <= cs_xx_r + mecr_pkg::CS_U_W'(pxx[15:0]);
            cs_yy_r <= cs_yy_r + mecr_pkg::CS_U_W'(pyy[15:0]);
            cs_xy_r <= cs_xy_r + mecr_pkg::CS_S_W'(pxy);
          end
          pl_r <= l_cur_r;
          pr_r <= ram_q;
          m2_r <= m1_r;
          m1_r <= m_cur_r;
        end
      endcase
    end
  end

  // ---------------- sliding window ----------------
  logic [mecr_pkg::CS_U_W-1:0]        sh_xx_r [NCOL];
  logic [mecr_pkg::CS_U_W-1:0]        sh_yy_r [NCOL];
  logic signed [mecr_pkg::CS_S_W-1:0] sh_xy_r [NCOL];
  logic [mecr_pkg::CS_U_W-1:0]        old_xx, old_yy;
  logic signed [mecr_pkg::CS_S_W-1:0] old_xy;
  logic [mecr_pkg::WIN_U_W-1:0]        win_xx_r, win_yy_r, win_xx_nxt, win_yy_nxt;
  logic signed [mecr_pkg::WIN_S_W-1:0] win_xy_r, win_xy_nxt;
  logic                                drop_old;

  assign drop_old = (pcol_r >= COL_W'(mecr_pkg::EDGE));
  assign old_xx   = drop_old ? sh_xx_r[NCOL-1] : '0;
  assign old_yy   = drop_old ? sh_yy_r[NCOL-1] : '0;
  assign old_xy   = drop_old ? sh_xy_r[NCOL-1] : '0;

  assign win_xx_nxt = win_xx_r + mecr_pkg::WIN_U_W'(cs_xx_r) - mecr_pkg::WIN_U_W'(old_xx);
  assign win_yy_nxt = win_yy_r + mecr_pkg::WIN_U_W'(cs_yy_r) - mecr_pkg::WIN_U_W'(old_yy);
  assign win_xy_nxt = win_xy_r + mecr_pkg::WIN_S_W'(cs_xy_r) - mecr_pkg::WIN_S_W'(old_xy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_xx_r <= '0;
      win_yy_r <= '0;
      win_xy_r <= '0;
    end else if (cmd.accept && col_cur == '0) begin
      win_xx_r <= '0;
      win_yy_r <= '0;
      win_xy_r <= '0;
    end else if (cmd.win_upd) begin
      win_xx_r <= win_xx_nxt;
      win_yy_r <= win_yy_nxt;
      win_xy_r <= win_xy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_upd) begin
      sh_xx_r[0] <= cs_xx_r;
      sh_yy_r[0] <= cs_yy_r;
      sh_xy_r[0] <= cs_xy_r;
      for (int i = 1; i < NCOL; i++) begin
        sh_xx_r[i] <= sh_xx_r[i-1];
        sh_yy_r[i] <= sh_yy_r[i-1];
        sh_xy_r[i] <= sh_xy_r[i-1];
      end
    end
  end

  // ---------------- discriminant and root ----------------
  logic signed [mecr_pkg::WIN_S_W-1:0]   dif, m_a;
  logic signed [2*mecr_pkg::WIN_S_W-1:0] m_p;
  logic [mecr_pkg::SQ_W-1:0]             sq_r;
  logic [mecr_pkg::DISC_W-1:0]           disc_r;
  logic [mecr_pkg::ROOT_W-1:0]           root_r;
  logic [mecr_pkg::REM_W-1:0]            rem_r, rem_sh, trial;

  assign dif = $signed({1'b0, win_xx_r}) - $signed({1'b0, win_yy_r});
  assign m_a = cmd.mul_disc ? win_xy_r : dif;
  assign m_p = m_a * m_a;

  assign rem_sh = {rem_r[mecr_pkg::REM_W-3:0], disc_r[mecr_pkg::DISC_W-1 -: 2]};
  assign trial  = mecr_pkg::REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.mul_sq) begin
      sq_r <= m_p[mecr_pkg::SQ_W-1:0];
    end
    if (cmd.mul_disc) begin
      disc_r <= mecr_pkg::DISC_W'(sq_r) + mecr_pkg::DISC_W'({m_p[mecr_pkg::SQ_W-1:0], 2'b00});
      root_r <= '0;
      rem_r  <= '0;
    end else if (cmd.sq_step) begin
      disc_r <= {disc_r[mecr_pkg::DISC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[mecr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[mecr_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // ---------------- output register ----------------
  logic [mecr_pkg::ROOT_W-1:0] tr, resp_full;
  logic                        out_tvalid_r, out_tlast_r;
  logic [mecr_pkg::RESP_W-1:0] oresp_r;
  logic [COL_W-1:0]            ocol_r;
  logic [ROW_W-1:0]            orow_r;

  assign tr        = mecr_pkg::ROOT_W'(win_xx_r) + mecr_pkg::ROOT_W'(win_yy_r);
  assign resp_full = tr - root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      oresp_r     <= resp_full[mecr_pkg::RESP_W-1:0];
      ocol_r      <= pcol_r - COL_W'(mecr_pkg::RADIUS + 1);
      orow_r      <= prow_r - ROW_W'(mecr_pkg::RADIUS + 1);
      out_tlast_r <= plast_r;
    end
  end

  assign stat.out_free = !out_tvalid_r || out_tready;
  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = {1'b0, orow_r, ocol_r, oresp_r};
  assign out_tlast     = out_tlast_r;

endmodule

FILE: rtl/min_eigenvalue_corner_response.sv
// ----------------------------------------------------------------------------
// min_eigenvalue_corner_response: Shi-Tomasi corner response over a pixel stream
// Doubled smaller eigenvalue of the 15x15 structure tensor per interior centre.
// ----------------------------------------------------------------------------
// Per-pixel work: pixels in the first 16 rows and at column 0 are only written
//   to the line store; a pixel that updates the window also gets a column pass
//   (51 line store reads on one RAM port), and one that closes a window also a
//   multiply and a 26-step bit-serial root; no new pixel is taken until it is done.
// Reset (synchronous, rst_n low): counters and window sums to zero, width 640,
//   height 480; the line store is not cleared and needs no clearing pass.
module min_eigenvalue_corner_response (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  mecr_pkg::reg_idx_t                 cfg_index,
  input  logic [mecr_pkg::CFG_W-1:0]         cfg_wdata,
  // pixel stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] green_value
  input  logic                               in_tuser,   // [0] frame_start
  // response stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mecr_pkg::OUT_DATA_W-1:0]    out_tdata,  // [24:0] response_doubled,
                                                         // [34:25] centre_col,
                                                         // [46:35] centre_row, [47] zero
  output logic                               out_tlast   // frame_last
);

  mecr_pkg::ctrl_cmd_t cmd;
  mecr_pkg::dp_stat_t  stat;

  // Sequencer: one word in flight. Each pixel is written to the line store on
  // the accept edge; pixels past the top border, apart from column 0, then get a
  // column pass (3 reads per stored row) that feeds the sliding 15-column window.
  mecr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: counters, line store, column sums, window sums, multiplier,
  // square root unit and the output register that frees the input side.
  mecr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_green       (in_tdata[mecr_pkg::PIX_W-1:0]),
    .in_frame_start (in_tuser),
    .cmd            (cmd),
    .stat           (stat),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register loaded while a result is pending");

  // a pixel that starts a column pass blocks the input on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && stat.need_col) |=> !in_tready)
    else $error("input taken during a column pass");

  // the response never exceeds the largest tensor trace, 29261250
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[mecr_pkg::RESP_W-1:0] <= 25'd29261250))
    else $error("response out of range");

endmodule
